// File: hdl/tlrhs_pkg.sv
package tlrhs_pkg;

    // Lamp encoding shared by both approaches and the display output
    localparam logic [1:0] LAMP_RED   = 2'd0;
    localparam logic [1:0] LAMP_AMBER = 2'd1;
    localparam logic [1:0] LAMP_GREEN = 2'd2;

    localparam int unsigned NORMAL_PHASES = 4;
    localparam int unsigned RUSH_PHASES   = 6;

    localparam int unsigned TPS_W   = 16;  // ticks_per_second width
    localparam int unsigned SECS_W  = 5;   // longest phase is 30 s
    localparam int unsigned COUNT_W = 21;  // tick counter, 30 * 65535 fits
    localparam int unsigned IDX_W   = 3;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    typedef logic [1:0] t_lamp;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic  phase_changed;
        t_lamp shown_light;
        t_lamp east_west_light;
        t_lamp north_south_light;
    } t_result;

    function automatic logic [SECS_W-1:0] phase_secs(input logic rush, input t_idx idx);
        logic [SECS_W-1:0] s;
        s = 5'd10;
        if (rush) begin
            unique case (idx)
                3'd0:    s = 5'd30;
                3'd1:    s = 5'd3;
                3'd2:    s = 5'd1;
                3'd3:    s = 5'd30;
                3'd4:    s = 5'd3;
                3'd5:    s = 5'd1;
                default: s = 5'd30;
            endcase
        end else begin
            unique case (idx)
                3'd0:    s = 5'd10;
                3'd1:    s = 5'd3;
                3'd2:    s = 5'd10;
                3'd3:    s = 5'd3;
                default: s = 5'd10;
            endcase
        end
        return s;
    endfunction

    function automatic t_lamp ns_lamp(input logic rush, input t_idx idx);
        t_lamp l;
        l = LAMP_RED;
        if (rush) begin
            unique case (idx)
                3'd3:    l = LAMP_GREEN;
                3'd4:    l = LAMP_AMBER;
                default: l = LAMP_RED;
            endcase
        end else begin
            unique case (idx)
                3'd2:    l = LAMP_GREEN;
                3'd3:    l = LAMP_AMBER;
                default: l = LAMP_RED;
            endcase
        end
        return l;
    endfunction

    // East-west sequence is the same in both schedules for the first phases
    function automatic t_lamp ew_lamp(input t_idx idx);
        t_lamp l;
        unique case (idx)
            3'd0:    l = LAMP_GREEN;
            3'd1:    l = LAMP_AMBER;
            default: l = LAMP_RED;
        endcase
        return l;
    endfunction

endpackage

// File: hdl/traffic_light_rush_hour_sequencer.sv
// Channel  | Dir | Signals                         | Payload
// ---------+-----+---------------------------------+--------------------------------------
// tick in  | in  | s_axis_tvalid/tready/tdata[7:0] | [0] rush_hour, [1] show_north_south
// lamps out| out | m_axis_tvalid/tready/tdata[7:0] | [1:0] NS, [3:2] EW, [5:4] shown, [6] chg
// config   | in  | i_cfg_wr_en, i_cfg_wr_data[15:0]| ticks_per_second, no read-back
//
// One tick transaction per cycle sustained while m_axis_tready is high; a tick is registered
// at acceptance, and the count/compare/lookup pass puts its result in the output register.
// The critical path is the 5x16 duration multiply feeding the 21-bit compare.
// Reset (synchronous, active low) clears both registers' valid flags and puts
// the sequencer in normal phase 0, NS red / EW green, 1000 ticks per second.
// A stall on m_axis holds the result; one more transaction still lands in the
// input register, after which s_axis_tready drops.
module traffic_light_rush_hour_sequencer
    import tlrhs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TPS_W-1:0]  i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [0] rush_hour, [1] show_north_south
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [1:0] north_south_light,
                                              // [3:2] east_west_light,
                                              // [5:4] shown_light, [6] phase_changed
);

    // config
    logic [TPS_W-1:0]   r_tps;

    // input register
    logic               r_in_valid;
    logic               r_in_rush;
    logic               r_in_show;

    // sequencer state
    t_idx               r_phase_idx;
    logic [COUNT_W-1:0] r_tick_cnt;
    logic               r_last_rush;
    t_lamp              r_ns;
    t_lamp              r_ew;

    // output register
    logic               r_out_valid;
    t_result            r_out;

    logic               w_advance;
    t_idx               w_cur;
    logic [SECS_W-1:0]  w_secs;
    logic [COUNT_W-1:0] w_duration;
    logic [COUNT_W-1:0] n_tick_cnt;
    logic               w_end;
    t_idx               w_idx;
    t_idx               n_phase_idx;
    t_lamp              n_ns;
    t_lamp              n_ew;
    t_result            n_out;

    // Item moves out of the input register when the output slot is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_comb begin
        // guard: out-of-table index reads as phase 0
        if (r_last_rush) begin
            w_cur = (r_phase_idx < IDX_W'(RUSH_PHASES)) ? r_phase_idx : '0;
        end else begin
            w_cur = (r_phase_idx < IDX_W'(NORMAL_PHASES)) ? r_phase_idx : '0;
        end
        w_secs     = phase_secs(r_last_rush, w_cur);
        w_duration = COUNT_W'(COUNT_W'(w_secs) * COUNT_W'(r_tps));
        n_tick_cnt = r_tick_cnt + COUNT_W'(1);
        w_end      = (n_tick_cnt >= w_duration);

        // realign on a schedule switch past the first two phases, then step
        w_idx = w_cur;
        if ((r_in_rush != r_last_rush) && (w_cur >= IDX_W'(2))) begin
            if (!r_last_rush) begin
                w_idx = w_cur + IDX_W'(1);
            end else begin
                w_idx = w_cur - IDX_W'(1);
            end
        end
        w_idx = w_idx + IDX_W'(1);
        if (r_in_rush) begin
            n_phase_idx = (w_idx >= IDX_W'(RUSH_PHASES)) ? '0 : w_idx;
        end else begin
            n_phase_idx = (w_idx >= IDX_W'(NORMAL_PHASES)) ? '0 : w_idx;
        end

        n_ns = w_end ? ns_lamp(r_in_rush, n_phase_idx) : r_ns;
        n_ew = w_end ? ew_lamp(n_phase_idx) : r_ew;

        n_out.north_south_light = n_ns;
        n_out.east_west_light   = n_ew;
        n_out.shown_light       = r_in_show ? n_ns : n_ew;
        n_out.phase_changed     = w_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase_idx <= '0;
            r_tick_cnt  <= '0;
            r_last_rush <= 1'b0;
            r_ns        <= LAMP_RED;
            r_ew        <= LAMP_GREEN;
        end else begin
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_ns <= n_ns;
                r_ew <= n_ew;
                if (w_end) begin
                    r_tick_cnt  <= '0;
                    r_phase_idx <= n_phase_idx;
                    r_last_rush <= r_in_rush;
                end else begin
                    r_tick_cnt  <= n_tick_cnt;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_rush <= s_axis_tdata[0];
            r_in_show <= s_axis_tdata[1];
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // Phase index stays inside the table of the schedule it belongs to
    a_idx_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_rush ? (r_phase_idx < IDX_W'(RUSH_PHASES))
                     : (r_phase_idx < IDX_W'(NORMAL_PHASES))))
        else $error("phase index outside schedule table");

    // A phase end restarts the tick count
    a_cnt_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_end) |=> (r_tick_cnt == '0))
        else $error("tick count not cleared at phase end");

    // Never two approaches showing non-red at once
    a_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[1:0] == LAMP_RED) || (m_axis_tdata[3:2] == LAMP_RED)))
        else $error("conflicting lamps");

    // Shown lamp equals one of the two approach lamps of the same item
    a_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> ((r_out.shown_light == r_out.north_south_light) ||
                       (r_out.shown_light == r_out.east_west_light)))
        else $error("shown lamp not from either approach");

endmodule
